// ===== hw/rtl/seso_pkg.sv =====
// Shared types, constants and helpers for the extended state observer.
`default_nettype none
package seso_pkg;
    localparam int unsigned DataWidth = 32;
    localparam int unsigned RegWidth = 31;
    localparam int unsigned FracBits = 16;
    localparam int unsigned IndexWidth = 3;

    localparam logic [RegWidth-1:0] StepTimeReset = 31'd66;
    localparam logic [RegWidth-1:0] PlantGainReset = 31'd65536;
    localparam logic [RegWidth-1:0] GainReset = 31'd0;
    localparam logic [RegWidth-1:0] LimitReset = 31'h7FFF_FFFF;

    typedef enum logic [IndexWidth-1:0] {
        REG_STEP_TIME = 3'd0,
        REG_PLANT_GAIN = 3'd1,
        REG_GAIN_ONE = 3'd2,
        REG_GAIN_TWO = 3'd3,
        REG_GAIN_THREE = 3'd4,
        REG_DRIVE_LIMIT = 3'd5
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_B3,
        ST_MUL_H3,
        ST_ADD_DIST,
        ST_DIV,
        ST_DIV_WAIT,
        ST_MUL_B2,
        ST_MUL_BU,
        ST_MUL_H2,
        ST_MUL_B1,
        ST_MUL_H1,
        ST_MUL_HP,
        ST_ADD_POS,
        ST_OUT
    } state_t;

    function automatic logic signed [DataWidth-1:0] sat_wide(
        input logic signed [DataWidth+1:0] v
    );
        logic signed [DataWidth-1:0] r;
        if (v > $signed({3'b000, {(DataWidth-1){1'b1}}})) begin
            r = {1'b0, {(DataWidth-1){1'b1}}};
        end
        else if (v < $signed({3'b111, {(DataWidth-1){1'b0}}})) begin
            r = {1'b1, {(DataWidth-1){1'b0}}};
        end
        else begin
            r = v[DataWidth-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DataWidth-1:0] add_sat(
        input logic signed [DataWidth-1:0] a,
        input logic signed [DataWidth-1:0] b
    );
        return sat_wide({{2{a[DataWidth-1]}}, a} + {{2{b[DataWidth-1]}}, b});
    endfunction

    function automatic logic signed [DataWidth-1:0] sub_sat(
        input logic signed [DataWidth-1:0] a,
        input logic signed [DataWidth-1:0] b
    );
        return sat_wide({{2{a[DataWidth-1]}}, a} - {{2{b[DataWidth-1]}}, b});
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/seso_mul.sv =====
// Bit-serial Q16.16 multiplier: unsigned 31-bit factor times signed 32-bit operand.
`default_nettype none
module seso_mul (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic [seso_pkg::RegWidth-1:0]          factor,
    input  wire logic signed [seso_pkg::DataWidth-1:0]  operand,
    output logic                                        done,
    output logic signed [seso_pkg::DataWidth-1:0]       product
);
    import seso_pkg::*;

    localparam int unsigned AccWidth = RegWidth + DataWidth + 1;
    localparam int unsigned CntWidth = $clog2(RegWidth + 1);

    logic [RegWidth-1:0]        mplier_reg;
    logic signed [AccWidth-1:0] mcand_reg;
    logic signed [AccWidth-1:0] acc_reg;
    logic [CntWidth-1:0]        count_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic signed [AccWidth-1:0] shifted;
    logic signed [AccWidth-1:0] hi_max;
    logic signed [AccWidth-1:0] lo_min;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                count_reg <= CntWidth'(RegWidth);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CntWidth'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mplier_reg <= factor;
            mcand_reg <= AccWidth'(operand);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    // An arithmetic shift rounds towards minus infinity, as required.
    assign shifted = acc_reg >>> FracBits;
    assign hi_max = AccWidth'({1'b0, {(DataWidth-1){1'b1}}});
    assign lo_min = -(AccWidth'({1'b0, {(DataWidth-1){1'b1}}})) - 1;

    always_comb
    begin
        if (shifted > hi_max)
        begin
            product = {1'b0, {(DataWidth-1){1'b1}}};
        end
        else if (shifted < lo_min)
        begin
            product = {1'b1, {(DataWidth-1){1'b0}}};
        end
        else
        begin
            product = shifted[DataWidth-1:0];
        end
    end

    assign done = done_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("multiplier done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> count_reg != '0)
        else $error("multiplier count ran out while busy");
    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg)
        else $error("multiplier did not start");
endmodule
`default_nettype wire

// ===== hw/rtl/seso_div.sv =====
// Restoring bit-serial divider for the Q16.16 quotient z_dist / b0.
`default_nettype none
module seso_div (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic signed [seso_pkg::DataWidth-1:0]  dividend,
    input  wire logic [seso_pkg::RegWidth-1:0]          divisor,
    output logic                                        done,
    output logic signed [seso_pkg::DataWidth-1:0]       quotient
);
    import seso_pkg::*;

    localparam int unsigned NumWidth = DataWidth + FracBits;
    localparam int unsigned CntWidth = $clog2(NumWidth + 1);

    logic [NumWidth-1:0]  num_reg;
    logic [RegWidth:0]    rem_reg;
    logic [RegWidth-1:0]  den_reg;
    logic                 neg_reg;
    logic [CntWidth-1:0]  count_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [RegWidth+1:0]  trial;
    logic [DataWidth-1:0] mag;
    logic [NumWidth-1:0]  q_mag;

    assign mag = dividend[DataWidth-1] ? (~dividend + 1'b1) : dividend;
    assign trial = {rem_reg, num_reg[NumWidth-1]} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                count_reg <= CntWidth'(NumWidth);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CntWidth'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The quotient bits shift into the numerator register as it empties.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {mag, {FracBits{1'b0}}};
            rem_reg <= '0;
            den_reg <= (divisor == '0) ? RegWidth'(1) : divisor;
            neg_reg <= dividend[DataWidth-1];
        end
        else if (busy_reg)
        begin
            if (!trial[RegWidth+1])
            begin
                rem_reg <= trial[RegWidth:0];
                num_reg <= {num_reg[NumWidth-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[RegWidth-1:0], num_reg[NumWidth-1]};
                num_reg <= {num_reg[NumWidth-2:0], 1'b0};
            end
        end
    end

    assign q_mag = num_reg;

    always_comb
    begin
        if (!neg_reg)
        begin
            if (q_mag[NumWidth-1:DataWidth-1] != '0)
            begin
                quotient = {1'b0, {(DataWidth-1){1'b1}}};
            end
            else
            begin
                quotient = q_mag[DataWidth-1:0];
            end
        end
        else
        begin
            if (q_mag > NumWidth'({1'b1, {(DataWidth-1){1'b0}}}))
            begin
                quotient = {1'b1, {(DataWidth-1){1'b0}}};
            end
            else
            begin
                quotient = ~q_mag[DataWidth-1:0] + 1'b1;
            end
        end
    end

    assign done = done_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> den_reg != '0)
        else $error("divider has a zero divisor");
    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg)
        else $error("divider did not start");
endmodule
`default_nettype wire

// ===== hw/rtl/second_order_extended_state_observer_top.sv =====
// Top level of the extended state observer with its sequencer and state.
//
// Channel  | Direction | Handshake       | Payload
// request  | in        | valid / ready   | measured, nominal_drive
// result   | out       | out_valid/ready | drive, est_position, est_rate, est_disturbance
// config   | in        | cfg_write       | cfg_index, cfg_data
//
// Each request runs seven serial multiplications and one serial division before the next can be taken.
// One request is worked on at a time; the next is taken once the sequencer is idle and the
// previous result has been taken, or is taken in the same cycle.
// Reset clears the estimates and loads the register defaults; there is no
// clearing pass.
`default_nettype none
module second_order_extended_state_observer_top (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [seso_pkg::DataWidth-1:0]  measured,
    input  wire logic signed [seso_pkg::DataWidth-1:0]  nominal_drive,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [seso_pkg::DataWidth-1:0]       drive,
    output logic signed [seso_pkg::DataWidth-1:0]       est_position,
    output logic signed [seso_pkg::DataWidth-1:0]       est_rate,
    output logic signed [seso_pkg::DataWidth-1:0]       est_disturbance,
    input  wire logic                                   cfg_write,
    input  wire logic [seso_pkg::IndexWidth-1:0]        cfg_index,
    input  wire logic [seso_pkg::RegWidth-1:0]          cfg_data
);
    import seso_pkg::*;

    typedef logic signed [DataWidth-1:0] word_t;

    logic [RegWidth-1:0] step_time_reg, plant_gain_reg, gain_one_reg;
    logic [RegWidth-1:0] gain_two_reg, gain_three_reg, drive_limit_reg;
    word_t z_pos_reg, z_rate_reg, z_dist_reg;
    word_t y_reg, u0_reg, e_reg, u_reg, inner_reg;
    word_t z_pos_next, z_rate_next, z_dist_next, u_next, inner_next;
    state_t state_reg, state_next;
    logic out_valid_reg, busy;
    word_t drive_reg, pos_out_reg, rate_out_reg, dist_out_reg;
    logic accept;

    logic mul_start, mul_done, div_start, div_done;
    logic [RegWidth-1:0] mul_factor;
    word_t mul_operand, mul_product, div_quotient, drive_clamped, lim;

    seso_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .factor(mul_factor), .operand(mul_operand),
        .done(mul_done), .product(mul_product)
    );

    seso_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(z_dist_reg), .divisor(plant_gain_reg),
        .done(div_done), .quotient(div_quotient)
    );

    assign in_ready = !busy && (!out_valid_reg || out_ready);
    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg <= StepTimeReset;
            plant_gain_reg <= PlantGainReset;
            gain_one_reg <= GainReset;
            gain_two_reg <= GainReset;
            gain_three_reg <= GainReset;
            drive_limit_reg <= LimitReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STEP_TIME: step_time_reg <= cfg_data;
                REG_PLANT_GAIN: plant_gain_reg <= cfg_data;
                REG_GAIN_ONE: gain_one_reg <= cfg_data;
                REG_GAIN_TWO: gain_two_reg <= cfg_data;
                REG_GAIN_THREE: gain_three_reg <= cfg_data;
                REG_DRIVE_LIMIT: drive_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            z_pos_reg <= '0;
            z_rate_reg <= '0;
            z_dist_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            z_pos_reg <= z_pos_next;
            z_rate_reg <= z_rate_next;
            z_dist_reg <= z_dist_next;
            if (state_reg == ST_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            y_reg <= measured;
            u0_reg <= nominal_drive;
        end
        if (state_reg == ST_ERR)
        begin
            e_reg <= sub_sat(y_reg, z_pos_reg);
        end
        u_reg <= u_next;
        inner_reg <= inner_next;
        if (state_reg == ST_OUT)
        begin
            drive_reg <= drive_clamped;
            pos_out_reg <= z_pos_reg;
            rate_out_reg <= z_rate_reg;
            dist_out_reg <= z_dist_reg;
        end
    end

    assign busy = state_reg != ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        z_pos_next = z_pos_reg;
        z_rate_next = z_rate_reg;
        z_dist_next = z_dist_reg;
        u_next = u_reg;
        inner_next = inner_reg;
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_factor = step_time_reg;
        mul_operand = inner_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                mul_start = 1'b1;
                mul_factor = gain_three_reg;
                mul_operand = sub_sat(y_reg, z_pos_reg);
                state_next = ST_MUL_B3;
            end
            ST_MUL_B3:
            begin
                if (mul_done)
                begin
                    inner_next = mul_product;
                    state_next = ST_MUL_H3;
                end
            end
            ST_MUL_H3:
            begin
                mul_start = 1'b1;
                state_next = ST_ADD_DIST;
            end
            ST_ADD_DIST:
            begin
                if (mul_done)
                begin
                    z_dist_next = add_sat(z_dist_reg, mul_product);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_start = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    u_next = sub_sat(u0_reg, div_quotient);
                    mul_start = 1'b1;
                    mul_factor = gain_two_reg;
                    mul_operand = e_reg;
                    state_next = ST_MUL_B2;
                end
            end
            ST_MUL_B2:
            begin
                if (mul_done)
                begin
                    inner_next = add_sat(z_dist_reg, mul_product);
                    mul_start = 1'b1;
                    mul_factor = plant_gain_reg;
                    mul_operand = u_reg;
                    state_next = ST_MUL_BU;
                end
            end
            ST_MUL_BU:
            begin
                if (mul_done)
                begin
                    inner_next = add_sat(inner_reg, mul_product);
                    state_next = ST_MUL_H2;
                end
            end
            ST_MUL_H2:
            begin
                mul_start = 1'b1;
                state_next = ST_MUL_B1;
            end
            ST_MUL_B1:
            begin
                if (mul_done)
                begin
                    z_rate_next = add_sat(z_rate_reg, mul_product);
                    mul_start = 1'b1;
                    mul_factor = gain_one_reg;
                    mul_operand = e_reg;
                    state_next = ST_MUL_H1;
                end
            end
            ST_MUL_H1:
            begin
                if (mul_done)
                begin
                    inner_next = add_sat(z_rate_reg, mul_product);
                    state_next = ST_MUL_HP;
                end
            end
            ST_MUL_HP:
            begin
                mul_start = 1'b1;
                state_next = ST_ADD_POS;
            end
            ST_ADD_POS:
            begin
                if (mul_done)
                begin
                    z_pos_next = add_sat(z_pos_reg, mul_product);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign lim = {1'b0, drive_limit_reg};

    always_comb
    begin
        drive_clamped = u_reg;
        if (u_reg >= lim)
        begin
            drive_clamped = lim;
        end
        if (drive_clamped <= -lim)
        begin
            drive_clamped = -lim;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive = drive_reg;
    assign est_position = pos_out_reg;
    assign est_rate = rate_out_reg;
    assign est_disturbance = dist_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n) accept |-> state_reg == ST_IDLE)
        else $error("request taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |-> !out_valid_reg || out_ready)
        else $error("result overwritten before it was taken");
    assert property (@(posedge clk) disable iff (!rst_n) !(mul_start && div_start))
        else $error("both arithmetic units started together");
endmodule
`default_nettype wire
